[hw/rtl/ialu_pkg.sv]
package ialu_pkg;

  // Opcode values as they arrive on the input channel.
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_MUL  = 5'd2;
  localparam logic [4:0] OP_DIV  = 5'd3;
  localparam logic [4:0] OP_MOD  = 5'd4;
  localparam logic [4:0] OP_AND  = 5'd5;
  localparam logic [4:0] OP_OR   = 5'd6;
  localparam logic [4:0] OP_XOR  = 5'd7;
  localparam logic [4:0] OP_NOT  = 5'd8;
  localparam logic [4:0] OP_NEG  = 5'd9;
  localparam logic [4:0] OP_SHL  = 5'd10;
  localparam logic [4:0] OP_LSR  = 5'd11;
  localparam logic [4:0] OP_ASR  = 5'd12;
  localparam logic [4:0] OP_BREV = 5'd13;
  localparam logic [4:0] OP_HREV = 5'd14;
  localparam logic [4:0] OP_ROL  = 5'd15;
  localparam logic [4:0] OP_ROR  = 5'd16;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OP   = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned HALF_BITS = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Operation class chosen by the front end.
  typedef enum logic [4:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_AND, K_OR, K_XOR, K_NOT, K_NEG,
    K_SHL, K_LSR, K_ASR, K_BREV, K_HREV, K_ROL, K_ROR, K_BAD
  } kind_t;

  // One queued operation.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] a;
    logic [31:0] b;
  } item_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

[hw/rtl/ialu_if.sv]
interface ialu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output op, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface ialu_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result;
  logic [1:0]  status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

[hw/rtl/integer_alu_32.sv]
// Channel  Dir  Payload                              Transfer
// in_ch    in   op[5], operand_a[32], operand_b[32]  valid && ready
// out_ch   out  result[32], status[2]                valid && ready
//
// One operation is taken per cycle while the four-entry queue has room.
// After its queue time an operation passes stage zero, the division stages and the
// output register; the division pipeline performs one restoring step per stage.
// Reset (rst_n low, synchronous) empties the queue and the pipeline.
// A stall on out_ch freezes the pipeline; the queue keeps accepting until full.
module integer_alu_32
  import ialu_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ialu_in_if.sink    in_ch,
  ialu_out_if.source out_ch
);

  queue_out_t q;
  logic       q_pop;

  ialu_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_out (q),
    .q_pop (q_pop)
  );

  ialu_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_in   (q),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // An error result always carries a zero word.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.result == 32'sd0))
    else $error("error status with nonzero result");

  // The unused status code never appears.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_BAD_OP ||
                      out_ch.status == ST_DIV_ZERO))
    else $error("invalid status code");
`endif

endmodule

[hw/rtl/ialu_front.sv]
module ialu_front
  import ialu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ialu_in_if.sink    in_ch,
  output queue_out_t q_out,
  input  logic       q_pop
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  item_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    count_r;
  item_t          dec;
  logic           push;
  logic           pop;

  // Classify the incoming opcode.
  always_comb begin
    dec.a = in_ch.operand_a;
    dec.b = in_ch.operand_b;
    case (in_ch.op)
      OP_ADD:  dec.kind = K_ADD;
      OP_SUB:  dec.kind = K_SUB;
      OP_MUL:  dec.kind = K_MUL;
      OP_DIV:  dec.kind = K_DIV;
      OP_MOD:  dec.kind = K_MOD;
      OP_AND:  dec.kind = K_AND;
      OP_OR:   dec.kind = K_OR;
      OP_XOR:  dec.kind = K_XOR;
      OP_NOT:  dec.kind = K_NOT;
      OP_NEG:  dec.kind = K_NEG;
      OP_SHL:  dec.kind = K_SHL;
      OP_LSR:  dec.kind = K_LSR;
      OP_ASR:  dec.kind = K_ASR;
      OP_BREV: dec.kind = K_BREV;
      OP_HREV: dec.kind = K_HREV;
      OP_ROL:  dec.kind = K_ROL;
      OP_ROR:  dec.kind = K_ROR;
      default: dec.kind = K_BAD;
    endcase
  end

  assign in_ch.ready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && (count_r != '0);

  assign q_out.valid = (count_r != '0);
  assign q_out.item  = mem_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[hw/rtl/ialu_back.sv]
module ialu_back
  import ialu_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  queue_out_t q_in,
  output logic       q_pop,
  ialu_out_if.source out_ch
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NB = (W + BYTE_BITS - 1) / BYTE_BITS;
  localparam int unsigned NH = (W + HALF_BITS - 1) / HALF_BITS;

  logic          adv;
  logic          v_r    [W+1];
  kind_t         kind_r [W+1];
  logic [1:0]    st_r   [W+1];
  logic [W-1:0]  res_r  [W+1];
  logic          negq_r [W+1];
  logic          negr_r [W+1];
  logic [W-1:0]  rem_r  [W+1];
  logic [W-1:0]  quo_r  [W+1];
  logic [W-1:0]  dvs_r  [W+1];
  logic signed [31:0] a0_r, b0_r;
  logic signed [63:0] prod;

  logic [W-1:0]  aw, bw, r0, mag_a, mag_b;
  logic [1:0]    st0;
  logic          neg_a, neg_b;

  logic          out_valid_r;
  logic signed [31:0] out_result_r;
  logic [1:0]    out_status_r;
  logic [W-1:0]  fin;
  logic signed [63:0] fin_ext;

  // Reverse units of a given size, taking at least one from the low end.
  function automatic logic [W-1:0] rev_bytes(input logic [W-1:0] x);
    logic [W-1:0] acc;
    int unsigned  n;
    acc = '0;
    n = 1;
    for (int unsigned j = 1; j < NB; j++) begin
      if ((x >> (BYTE_BITS * j)) != '0) n = j + 1;
    end
    for (int unsigned j = 0; j < NB; j++) begin
      if (j < n) begin
        acc = acc | (((x >> (BYTE_BITS * j)) & W'(8'hFF)) << (BYTE_BITS * (n - 1 - j)));
      end
    end
    return acc;
  endfunction

  function automatic logic [W-1:0] rev_halves(input logic [W-1:0] x);
    logic [W-1:0] acc;
    int unsigned  n;
    acc = '0;
    n = 1;
    for (int unsigned j = 1; j < NH; j++) begin
      if ((x >> (HALF_BITS * j)) != '0) n = j + 1;
    end
    for (int unsigned j = 0; j < NH; j++) begin
      if (j < n) begin
        acc = acc | (((x >> (HALF_BITS * j)) & W'(16'hFFFF)) << (HALF_BITS * (n - 1 - j)));
      end
    end
    return acc;
  endfunction

  // The whole pipeline moves when the output register can take a word.
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv;

  // Operand setup and the operations computed without the divider or multiplier.
  always_comb begin
    logic signed [63:0] ea, eb;
    ea    = 64'($signed(q_in.item.a));
    eb    = 64'($signed(q_in.item.b));
    aw    = ea[W-1:0];
    bw    = eb[W-1:0];
    neg_a = aw[W-1];
    neg_b = bw[W-1];
    mag_a = neg_a ? (W'(0) - aw) : aw;
    mag_b = neg_b ? (W'(0) - bw) : bw;
    st0   = ST_OK;
    case (q_in.item.kind)
      K_ADD:  r0 = aw + bw;
      K_SUB:  r0 = aw - bw;
      K_AND:  r0 = aw & bw;
      K_OR:   r0 = aw | bw;
      K_XOR:  r0 = aw ^ bw;
      K_NOT:  r0 = ~aw;
      K_NEG:  r0 = W'(0) - aw;
      K_SHL:  r0 = {aw[W-2:0], 1'b0};
      K_LSR:  r0 = {1'b0, aw[W-1:1]};
      K_ASR:  r0 = {aw[W-1], aw[W-1:1]};
      K_BREV: r0 = rev_bytes(aw);
      K_HREV: r0 = rev_halves(aw);
      K_ROL:  r0 = {aw[W-2:0], aw[W-1]};
      K_ROR:  r0 = {aw[0], aw[W-1:1]};
      K_DIV, K_MOD: begin
        r0 = '0;
        if (bw == '0) st0 = ST_DIV_ZERO;
      end
      K_MUL:  r0 = '0;
      default: begin
        r0  = '0;
        st0 = ST_BAD_OP;
      end
    endcase
  end

  // Stage zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r[0] <= q_in.item.kind;
      st_r[0]   <= st0;
      res_r[0]  <= r0;
      negq_r[0] <= neg_a ^ neg_b;
      negr_r[0] <= neg_a;
      rem_r[0]  <= '0;
      quo_r[0]  <= mag_a;
      dvs_r[0]  <= mag_b;
      a0_r      <= q_in.item.a;
      b0_r      <= q_in.item.b;
    end
  end

  // The operands are 32-bit fields, so the low word of the product comes from
  // a signed 32 by 32 multiply for every word width.
  assign prod = a0_r * b0_r;

  // One restoring division step per stage; stage one also holds the product.
  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0]   trial;
    logic         ge;
    logic [W:0]   diff;

    assign trial = {rem_r[k-1], quo_r[k-1][W-1]};
    assign ge    = trial >= {1'b0, dvs_r[k-1]};
    assign diff  = trial - {1'b0, dvs_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kind_r[k] <= kind_r[k-1];
        st_r[k]   <= st_r[k-1];
        negq_r[k] <= negq_r[k-1];
        negr_r[k] <= negr_r[k-1];
        dvs_r[k]  <= dvs_r[k-1];
        rem_r[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
        quo_r[k]  <= {quo_r[k-1][W-2:0], ge};
        if (k == 1 && kind_r[k-1] == K_MUL) begin
          res_r[k] <= prod[W-1:0];
        end else begin
          res_r[k] <= res_r[k-1];
        end
      end
    end
  end

  // Sign fix of quotient and remainder, then widen to the result field.
  always_comb begin
    fin = res_r[W];
    if (st_r[W] == ST_OK) begin
      if (kind_r[W] == K_DIV) begin
        fin = negq_r[W] ? (W'(0) - quo_r[W]) : quo_r[W];
      end else if (kind_r[W] == K_MOD) begin
        fin = negr_r[W] ? (W'(0) - rem_r[W]) : rem_r[W];
      end
    end
    fin_ext = 64'($signed(fin));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= fin_ext[31:0];
      out_status_r <= st_r[W];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;
  assign out_ch.status = out_status_r;

endmodule

[dv/integer_alu_32_tb.sv]
module integer_alu_32_tb
  import ialu_pkg::*;
;

  // Expected result of one operation.
  typedef struct {
    logic signed [31:0] result;
    logic [1:0]         status;
  } alu_result_t;

  // One row of directed stimulus; check_fixed selects the typed-in answer.
  typedef struct {
    logic [4:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 check_fixed;
    logic signed [31:0] result;
    logic [1:0]         status;
  } vector_t;

  localparam int NUM_RANDOM = 480;
  localparam int LATENCY = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ialu_in_if  in_ch();
  ialu_out_if out_ch();

  integer_alu_32 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Clock with a period of four units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alu_result_t pending_results[$];
  int  mismatch_count = 0;
  int  checked_count = 0;
  bit  quiet_phase = 1'b0;
  bit  hold_off_req = 1'b0;
  bit  stimulus_done = 1'b0;
  vector_t vectors[$];

  // Report one mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Reverse the significant units of a word, units taken from the low end.
  function automatic logic [31:0] reverse_significant(input logic [31:0] x,
                                                      input int unit_bits);
    logic [31:0] acc;
    logic [31:0] unit_mask;
    acc = '0;
    unit_mask = (unit_bits == BYTE_BITS) ? 32'hFF : 32'hFFFF;
    do begin
      acc = (acc << unit_bits) + (x & unit_mask);
      x = x >> unit_bits;
    end while (x != 0);
    return acc;
  endfunction

  // Compute the ALU result for one operation.
  function automatic alu_result_t compute_alu(input logic [4:0] op,
                                              input logic [31:0] a,
                                              input logic [31:0] b);
    alu_result_t r;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    r.result = '0;
    r.status = ST_OK;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    case (op)
      OP_ADD:  r.result = a + b;
      OP_SUB:  r.result = a - b;
      OP_MUL:  r.result = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          r.status = ST_DIV_ZERO;
        end else if (op == OP_DIV) begin
          q = mag_a / mag_b;
          r.result = (a[31] != b[31]) ? -q : q;
        end else begin
          q = mag_a % mag_b;
          r.result = a[31] ? -q : q;
        end
      end
      OP_AND:  r.result = a & b;
      OP_OR:   r.result = a | b;
      OP_XOR:  r.result = a ^ b;
      OP_NOT:  r.result = ~a;
      OP_NEG:  r.result = -a;
      OP_SHL:  r.result = a << 1;
      OP_LSR:  r.result = a >> 1;
      OP_ASR:  r.result = {a[31], a[31:1]};
      OP_BREV: r.result = reverse_significant(a, BYTE_BITS);
      OP_HREV: r.result = reverse_significant(a, HALF_BITS);
      OP_ROL:  r.result = {a[30:0], a[31]};
      OP_ROR:  r.result = {a[0], a[31:1]};
      default: r.status = ST_BAD_OP;
    endcase
    return r;
  endfunction

  // Add one directed row.
  function automatic void add_row(input logic [4:0] op, input logic [31:0] a,
                                  input logic [31:0] b, input bit fixed = 1'b0,
                                  input logic [31:0] res = '0,
                                  input logic [1:0] st = ST_OK);
    vector_t v;
    v.op = op;
    v.a = a;
    v.b = b;
    v.check_fixed = fixed;
    v.result = res;
    v.status = st;
    vectors.push_back(v);
  endfunction

  // Offer one operation and wait for its transfer.
  task automatic send_op(input logic [4:0] op, input logic [31:0] a,
                         input logic [31:0] b, input bit fixed,
                         input logic [31:0] res, input logic [1:0] st);
    alu_result_t exp;
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (fixed) begin
      exp.result = res;
      exp.status = st;
    end else begin
      exp = compute_alu(op, a, b);
    end
    pending_results.push_back(exp);
  endtask

  // Random operand with a bias toward corner values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 3);
      4: return $urandom_range(0, 16'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus.
  initial begin
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    in_ch.valid     = 1'b0;
    in_ch.op        = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;

    add_row(OP_ADD, 32'h7FFF_FFFF, 32'h1, 1'b1, 32'h8000_0000, ST_OK);
    add_row(OP_SUB, 32'h8000_0000, 32'h1, 1'b1, 32'h7FFF_FFFF, ST_OK);
    add_row(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h1, ST_OK);
    add_row(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK);
    add_row(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK);
    add_row(OP_DIV, 32'h1234, 32'h0, 1'b1, 32'h0, ST_DIV_ZERO);
    add_row(OP_MOD, 32'hFFFF_FFF9, 32'h0, 1'b1, 32'h0, ST_DIV_ZERO);
    add_row(OP_DIV, 32'hFFFF_FFF9, 32'h2);
    add_row(OP_MOD, 32'hFFFF_FFF9, 32'h2);
    add_row(OP_MOD, 32'h7, 32'hFFFF_FFFE);
    add_row(OP_AND, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    add_row(OP_OR, 32'h0, 32'h5A5A_5A5A);
    add_row(OP_XOR, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
    add_row(OP_NOT, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF, ST_OK);
    add_row(OP_NEG, 32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, ST_OK);
    add_row(OP_SHL, 32'hC000_0001, 32'hFFFF_FFFF);
    add_row(OP_LSR, 32'h8000_0001, 32'h0);
    add_row(OP_ASR, 32'h8000_0001, 32'h0);
    add_row(OP_BREV, 32'h0, 32'h0, 1'b1, 32'h0, ST_OK);
    add_row(OP_BREV, 32'h0001_2345, 32'h0);
    add_row(OP_BREV, 32'h8000_0000, 32'h0);
    add_row(OP_HREV, 32'hFFFF_1234, 32'h0);
    add_row(OP_HREV, 32'h0000_1234, 32'h0);
    add_row(OP_ROL, 32'h8000_0001, 32'h0);
    add_row(OP_ROR, 32'h8000_0001, 32'h0);
    add_row(5'd17, 32'h1, 32'h1, 1'b1, 32'h0, ST_BAD_OP);
    add_row(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_BAD_OP);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      send_op(vectors[i].op, vectors[i].a, vectors[i].b, vectors[i].check_fixed,
              vectors[i].result, vectors[i].status);
    end

    // Pause until every result has drained.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 150) hold_off_req <= 1'b1;
      if (n == NUM_RANDOM - 80) quiet_phase = 1'b1;
      op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                       : 5'($urandom_range(0, 16));
      a = pick_operand();
      b = pick_operand();
      send_op(op, a, b, 1'b0, '0, ST_OK);
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Result receiver with random stalls and one long hold-off.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every transfer on the result channel with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.result, '0);
      end else begin
        exp = pending_results.pop_front();
        checked_count++;
        if (out_ch.result !== exp.result)
          report_mismatch("result", out_ch.result, exp.result);
        if (out_ch.status !== exp.status)
          report_mismatch("status", 32'(out_ch.status), 32'(exp.status));
      end
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    $display("Checked %0d results over all opcodes, error codes and operand extremes,",
             checked_count);
    $display("with random stalls on both channels and a long receiver hold-off.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
